// File: rtl/core/wga_pkg.sv
// Shared constants, types and command structures of the weighted Gram accumulator.
`default_nettype none

package wga_pkg;

  // Number of basis functions. The 4-bit index fields limit it to 16.
  localparam int unsigned BASIS_COUNT = 16;
  localparam int unsigned BASIS_W     = (BASIS_COUNT > 1) ? $clog2(BASIS_COUNT) : 1;
  localparam int unsigned ENT_W       = 2 * BASIS_W;
  localparam int unsigned ENTRY_COUNT = 1 << ENT_W;

  // Field widths.
  localparam int unsigned OP_W     = 2;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned PHI_W    = 16;
  localparam int unsigned WGT_W    = 32;
  localparam int unsigned ACC_W    = 64;
  localparam int unsigned PMAG_W   = 31;  // |phi_i * phi_j| <= 2^30
  localparam int unsigned FULL_W   = 62;  // |p| * w < 2^62
  localparam int unsigned RND_SH   = 16;  // Q18.46 to Q34.30
  localparam int unsigned TERM_W   = FULL_W - RND_SH;

  // Index range limit, one bit wider than the index fields.
  localparam logic [IDX_W:0] BASIS_LIM  = (IDX_W + 1)'(BASIS_COUNT);
  localparam logic [BASIS_W-1:0] IDX_LAST = BASIS_W'(BASIS_COUNT - 1);

  // Operation codes of an input word.
  typedef enum logic [OP_W-1:0] {
    OP_LOAD   = 2'd0,
    OP_COMMIT = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic               load_en;
    logic               clear_en;
    logic               weight_ld;
    logic               issue_vld;
    logic [BASIS_W-1:0] issue_row;
    logic [BASIS_W-1:0] issue_col;
    logic               read_en;
    logic               out_load;
  } wga_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pipe_busy;
  } wga_sts_t;

endpackage

`default_nettype wire

// File: rtl/core/wga_ctrl.sv
// Controller state machine: accepts words, walks the matrix on a commit, sequences reads.
`default_nettype none

module wga_ctrl
  import wga_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [OP_W-1:0]  opcode_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output wga_cmd_t              cmd_o,
  input  wire wga_sts_t         sts_i
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_COMMIT = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_READ   = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [BASIS_W-1:0] row_q, row_d;
  logic [BASIS_W-1:0] col_q, col_d;
  logic               out_valid_q, out_valid_d;
  logic               in_acc;
  logic               out_slot;
  opcode_e            op;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign op          = opcode_e'(opcode_i);
  assign out_valid_o = out_valid_q;
  assign out_slot    = !out_valid_q || out_ready_i;

  // Next state, walk counters and datapath commands.
  always_comb begin
    state_d        = state_q;
    row_d          = row_q;
    col_d          = col_q;
    cmd_o          = '0;
    cmd_o.issue_row = row_q;
    cmd_o.issue_col = col_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (op)
            OP_LOAD:   cmd_o.load_en = 1'b1;
            OP_COMMIT: begin
              cmd_o.weight_ld = 1'b1;
              row_d   = '0;
              col_d   = '0;
              state_d = ST_COMMIT;
            end
            OP_READ: begin
              cmd_o.read_en = 1'b1;
              state_d = ST_READ;
            end
            OP_CLEAR:  cmd_o.clear_en = 1'b1;
            default:   cmd_o.clear_en = 1'b0;
          endcase
        end
      end
      ST_COMMIT: begin
        // One matrix entry enters the multiply-accumulate pipeline per cycle.
        cmd_o.issue_vld = 1'b1;
        if (col_q == IDX_LAST) begin
          col_d = '0;
          if (row_q == IDX_LAST) begin
            row_d   = '0;
            state_d = ST_DRAIN;
          end else begin
            row_d = row_q + BASIS_W'(1);
          end
        end else begin
          col_d = col_q + BASIS_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        // Read data is in the datapath; move it out once the output slot frees.
        if (out_slot) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output valid: set on load, cleared when the word is taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/wga_dp.sv
// Datapath: point buffer, Gram matrix memory and the multiply-accumulate pipeline.
`default_nettype none

module wga_dp
  import wga_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic [IDX_W-1:0]         row_index_i,
  input  wire logic [IDX_W-1:0]         column_index_i,
  input  wire logic signed [PHI_W-1:0]  basis_value_i,
  input  wire logic [WGT_W-1:0]         point_weight_i,
  input  wire wga_cmd_t                 cmd_i,
  output wga_sts_t                      sts_o,
  output logic signed [ACC_W-1:0]       entry_value_o,
  output logic                          overflow_seen_o
);

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic [FULL_W-1:0] RND_HALF = FULL_W'(1) << (RND_SH - 1);

  // Storage.
  logic signed [PHI_W-1:0] pbuf_mem [BASIS_COUNT];
  logic [ACC_W-1:0]        gram_mem [ENTRY_COUNT];
  logic [ENTRY_COUNT-1:0]  ent_vld_q;
  logic                    ovf_q;
  logic [WGT_W-1:0]        weight_q;

  // Pipeline registers.
  logic                    v1_q, v2_q, v3_q, v4_q;
  logic [ENT_W-1:0]        k1_q, k2_q, k3_q, k4_q;
  logic signed [PHI_W-1:0] phi_i_q, phi_j_q;
  logic [PMAG_W-1:0]       pmag_q;
  logic                    neg2_q, neg3_q, neg4_q;
  logic [FULL_W-1:0]       full_q;
  logic [TERM_W-1:0]       term_q;

  // Matrix read port.
  logic [ACC_W-1:0]        rd_data_q;
  logic                    rd_vld_q;
  logic                    rd_ok_q;
  logic                    gram_rd_en;
  logic [ENT_W-1:0]        gram_rd_addr;
  logic                    rd_in_range;

  // Output word.
  logic signed [ACC_W-1:0] entry_q;
  logic                    ovf_out_q;

  logic                    load_ok;
  logic [PHI_W-1:0]        mag_i, mag_j;
  logic [2*PHI_W-1:0]      pmag_full;
  logic [PMAG_W+WGT_W-1:0] prod_full;
  logic [FULL_W-1:0]       rnd_sum;
  logic signed [ACC_W:0]   acc_ext;
  logic signed [ACC_W:0]   term_ext;
  logic signed [ACC_W:0]   sum_ext;
  logic                    sat;
  logic [ACC_W-1:0]        sum_sat;

  assign sts_o.pipe_busy = v1_q || v2_q || v3_q || v4_q;
  assign entry_value_o   = entry_q;
  assign overflow_seen_o = ovf_out_q;

  assign load_ok     = ({1'b0, row_index_i} < BASIS_LIM);
  assign rd_in_range = ({1'b0, row_index_i} < BASIS_LIM) &&
                       ({1'b0, column_index_i} < BASIS_LIM);

  // Point buffer: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_en && load_ok) begin
      pbuf_mem[row_index_i[BASIS_W-1:0]] <= basis_value_i;
    end
    if (cmd_i.issue_vld) begin
      phi_i_q <= pbuf_mem[cmd_i.issue_row];
      phi_j_q <= pbuf_mem[cmd_i.issue_col];
      k1_q    <= {cmd_i.issue_row, cmd_i.issue_col};
    end
  end

  // Weight of the point being committed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.weight_ld) begin
      weight_q <= point_weight_i;
    end
  end

  // Stage 2: magnitude product of the two basis values and its sign.
  assign mag_i     = phi_i_q[PHI_W-1] ? PHI_W'(-phi_i_q) : PHI_W'(phi_i_q);
  assign mag_j     = phi_j_q[PHI_W-1] ? PHI_W'(-phi_j_q) : PHI_W'(phi_j_q);
  assign pmag_full = mag_i * mag_j;

  always_ff @(posedge clk_i) begin
    pmag_q <= pmag_full[PMAG_W-1:0];
    neg2_q <= phi_i_q[PHI_W-1] ^ phi_j_q[PHI_W-1];
    k2_q   <= k1_q;
  end

  // Stage 3: weighting, exact in Q18.46.
  assign prod_full = pmag_q * weight_q;

  always_ff @(posedge clk_i) begin
    full_q <= prod_full[FULL_W-1:0];
    neg3_q <= neg2_q;
    k3_q   <= k2_q;
  end

  // Stage 4: round to nearest, ties away from zero, on the magnitude.
  assign rnd_sum = full_q + RND_HALF;

  always_ff @(posedge clk_i) begin
    term_q <= rnd_sum[FULL_W-1:RND_SH];
    neg4_q <= neg3_q;
    k4_q   <= k3_q;
  end

  // Matrix read: the walk reads the entry one stage ahead of its update.
  assign gram_rd_en   = v3_q || cmd_i.read_en;
  assign gram_rd_addr = v3_q ? k3_q
                             : {row_index_i[BASIS_W-1:0], column_index_i[BASIS_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (gram_rd_en) begin
      rd_data_q <= gram_mem[gram_rd_addr];
      rd_vld_q  <= ent_vld_q[gram_rd_addr];
    end
    if (cmd_i.read_en) begin
      rd_ok_q <= rd_in_range;
    end
  end

  // Stage 5: saturating add or subtract of the term.
  assign acc_ext  = rd_vld_q ? {rd_data_q[ACC_W-1], rd_data_q} : '0;
  assign term_ext = {{(ACC_W + 1 - TERM_W){1'b0}}, term_q};
  assign sum_ext  = neg4_q ? (acc_ext - term_ext) : (acc_ext + term_ext);
  assign sat      = sum_ext[ACC_W] ^ sum_ext[ACC_W-1];
  assign sum_sat  = sat ? (sum_ext[ACC_W] ? ACC_MIN : ACC_MAX) : sum_ext[ACC_W-1:0];

  always_ff @(posedge clk_i) begin
    if (v4_q) begin
      gram_mem[k4_q] <= sum_sat;
    end
  end

  // Entry valid bits, overflow flag and stage valids.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      ovf_q     <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      v4_q      <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue_vld;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (cmd_i.clear_en) begin
        ent_vld_q <= '0;
        ovf_q     <= 1'b0;
      end else if (v4_q) begin
        ent_vld_q[k4_q] <= 1'b1;
        if (sat) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      entry_q   <= (rd_ok_q && rd_vld_q) ? rd_data_q : '0;
      ovf_out_q <= ovf_q;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/weighted_gram_accumulator.sv
// Top level of the weighted Gram accumulator: controller and datapath.
//
//   Channel  Signals                                             Direction
//   in       in_valid_i / in_ready_o, opcode_i, row_index_i,     input word
//            column_index_i, basis_value_i, point_weight_i
//   out      out_valid_o / out_ready_i, entry_value_o,           output word
//            overflow_seen_o
//
// A read waits for the output register to free. In a commit, one matrix
// entry per cycle goes through a five-stage multiply-accumulate pipeline
// that uses the matrix memory read port and its separate write port, and the
// pipeline drains before the next word is taken. Reset clears all entries at
// once through per-entry valid bits; a clear word does the same. A stalled
// output holds its word while the input side keeps taking loads, commits and
// clears.
`default_nettype none

module weighted_gram_accumulator
  import wga_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [OP_W-1:0]          opcode_i,
  input  wire logic [IDX_W-1:0]         row_index_i,
  input  wire logic [IDX_W-1:0]         column_index_i,
  input  wire logic signed [PHI_W-1:0]  basis_value_i,
  input  wire logic [WGT_W-1:0]         point_weight_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [ACC_W-1:0]       entry_value_o,
  output logic                          overflow_seen_o
);

  wga_cmd_t cmd;
  wga_sts_t sts;

  // Sequencing.
  wga_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  // Storage and arithmetic.
  wga_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .row_index_i    (row_index_i),
    .column_index_i (column_index_i),
    .basis_value_i  (basis_value_i),
    .point_weight_i (point_weight_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .entry_value_o  (entry_value_o),
    .overflow_seen_o(overflow_seen_o)
  );

endmodule

`default_nettype wire
